/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/ds2a_pkg.sv */
// ----------------------------------------------------------------------------
// ds2a_pkg
// Shared widths, register indexes and the result beat type of the
// 2x2 averaging downscaler.
// ----------------------------------------------------------------------------
package ds2a_pkg;

  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned PAIR_W     = 9;
  localparam int unsigned BLOCK_W    = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LINES = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] avg_pixel;
    logic [PIXEL_W-1:0] frame_max;
    logic               frame_last;
  } result_t;

endpackage

/* design/ds2a_ram.sv */
// ----------------------------------------------------------------------------
// ds2a_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ds2a_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ds2a_obuf.sv */
// ----------------------------------------------------------------------------
// ds2a_obuf
// Two-entry output buffer: an output register plus a skid entry, so the
// pixel side keeps moving while a result beat waits.
// ----------------------------------------------------------------------------
module ds2a_obuf
  import ds2a_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t out_data_o,
  output logic    full_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign full_o      = skid_valid_q;

endmodule

/* design/downscale_2x2_average.sv */
// ----------------------------------------------------------------------------
// downscale_2x2_average
// 2x2 box-filter downsampler with running frame maximum and last-pixel flag.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and sustains that rate with no
// bubbles while the result side keeps up; each pixel costs at most one access
// to the single line store (pair-sum write on even rows, read issued on the
// even column of odd rows); a block's result beat is pushed on accepting the
// pixel closing it. A two-entry output buffer lets input continue while a
// result beat is stalled; input stalls only once both entries are full.
// Frame size registers clamp to 2..MAX_COLS / 2..MAX_LINES when written and
// should be written between frames; a trailing odd row or column yields no
// output. The line store needs no clearing after reset.
module downscale_2x2_average
  import ds2a_pkg::*;
#(
  parameter int unsigned MAX_COLS  = 512,
  parameter int unsigned MAX_LINES = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_W-1:0]    pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_W-1:0]    avg_pixel_o,
  output logic [PIXEL_W-1:0]    frame_max_o,
  output logic                  frame_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned CW     = $clog2(MAX_COLS + 1);
  localparam int unsigned RW     = $clog2(MAX_LINES + 1);
  localparam int unsigned DEPTH  = MAX_COLS / 2;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CLW    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int unsigned RLW    = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;
  localparam int unsigned COLS_R = (MAX_COLS < 512) ? MAX_COLS : 512;
  localparam int unsigned LINE_R = (MAX_LINES < 512) ? MAX_LINES : 512;

  // frame size, stored already clamped
  logic [CW-1:0] cols_q, cols_d;
  logic [RW-1:0] lines_q, lines_d;
  logic [CLW-1:0] cfg_cols_ext;
  logic [RLW-1:0] cfg_lines_ext;

  logic [CW-1:0]      col_q, col_d;
  logic [RW-1:0]      row_q, row_d;
  logic [PIXEL_W-1:0] held_q, held_d;
  logic [PIXEL_W-1:0] max_q, max_d;

  logic               accept;
  logic               buf_full;
  logic [CW-1:0]      cols_e;
  logic [RW-1:0]      lines_e;
  logic [CW:0]        col_nx;
  logic [RW:0]        row_nx;
  logic               line_end, frame_end;
  logic [PAIR_W-1:0]  pair;
  logic [BLOCK_W-1:0] block_sum;
  logic [PIXEL_W-1:0] avg;
  logic               in_block_col;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_addr;
  logic [PAIR_W-1:0]  ram_rdata;
  logic               push;
  result_t            push_data, out_data;

  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_cols_ext  = CLW'(cfg_data_i);
  assign cfg_lines_ext = RLW'(cfg_data_i);

  always_comb begin
    cols_d  = cols_q;
    lines_d = lines_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_COLS: begin
          if (cfg_cols_ext < CLW'(2)) begin
            cols_d = CW'(2);
          end else if (cfg_cols_ext > CLW'(MAX_COLS)) begin
            cols_d = CW'(MAX_COLS);
          end else begin
            cols_d = CW'(cfg_cols_ext);
          end
        end
        REG_IMAGE_LINES: begin
          if (cfg_lines_ext < RLW'(2)) begin
            lines_d = RW'(2);
          end else if (cfg_lines_ext > RLW'(MAX_LINES)) begin
            lines_d = RW'(MAX_LINES);
          end else begin
            lines_d = RW'(cfg_lines_ext);
          end
        end
        default: begin
          cols_d  = cols_q;
          lines_d = lines_q;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pixel datapath
  // --------------------------------------------------------------------------
  assign accept  = in_valid_i & ~in_stall_o;
  assign cols_e  = {cols_q[CW-1:1], 1'b0};
  assign lines_e = {lines_q[RW-1:1], 1'b0};

  assign col_nx    = {1'b0, col_q} + (CW+1)'(1);
  assign row_nx    = {1'b0, row_q} + (RW+1)'(1);
  assign line_end  = col_nx >= {1'b0, cols_q};
  assign frame_end = line_end && (row_nx >= {1'b0, lines_q});

  assign in_block_col = col_q[0] && (col_q < cols_e);
  assign pair         = PAIR_W'(held_q) + PAIR_W'(pixel_i);
  assign block_sum    = BLOCK_W'(ram_rdata) + BLOCK_W'(pair);
  assign avg          = block_sum[BLOCK_W-1:2];
  assign ram_addr     = col_q[AW:1];

  // write pair sums on even rows, prefetch them on the even column of odd rows
  assign ram_we = accept && in_block_col && !row_q[0];
  assign ram_re = accept && !col_q[0] && row_q[0];
  assign push   = accept && in_block_col && row_q[0] && (row_q < lines_e);

  always_comb begin
    held_d = held_q;
    max_d  = max_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (!col_q[0]) begin
        held_d = pixel_i;
      end
      if (push && (avg > max_q)) begin
        max_d = avg;
      end
      if (line_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_nx[RW-1:0];
        if (frame_end) begin
          max_d = '0;
        end
      end else begin
        col_d = col_nx[CW-1:0];
      end
    end
  end

  always_comb begin
    push_data.avg_pixel  = avg;
    push_data.frame_max  = (avg > max_q) ? avg : max_q;
    push_data.frame_last = (row_q == lines_e - RW'(1)) && (col_q == cols_e - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= CW'(COLS_R);
      lines_q <= RW'(LINE_R);
      col_q   <= '0;
      row_q   <= '0;
      held_q  <= '0;
      max_q   <= '0;
    end else begin
      cols_q  <= cols_d;
      lines_q <= lines_d;
      col_q   <= col_d;
      row_q   <= row_d;
      held_q  <= held_d;
      max_q   <= max_d;
    end
  end

  ds2a_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (pair),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  ds2a_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (buf_full)
  );

  assign in_stall_o   = buf_full;
  assign avg_pixel_o  = out_data.avg_pixel;
  assign frame_max_o  = out_data.frame_max;
  assign frame_last_o = out_data.frame_last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_stall_needs_beat, !in_stall_o || out_valid_o,
              "input stalled with no result beat pending")
  `ASSERT_CLK(a_store_one_access, !(ram_we && ram_re),
              "line store written and read in the same cycle")
  `ASSERT_CLK(a_last_wraps, accept && frame_end |=> (col_q == '0) && (row_q == '0),
              "counters not cleared after last pixel of frame")
  `ASSERT_CLK(a_max_rises, accept && !frame_end |=> max_q >= $past(max_q),
              "frame maximum dropped inside a frame")

endmodule
